@@ hdl/isu_pkg.sv @@
// Shared types and constants for the 1D Ising spin update unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

    localparam int ACTION_W = 2;
    localparam int SITE_W   = 10;
    localparam int RAND_W   = 32;
    localparam int COUNT_W  = 32;
    localparam int SCNT_W   = 11;
    localparam int THR_W    = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;
    localparam int NUM_THR    = 6;
    localparam int THR_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FIRST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LAST   = 3'd6;

    // thresholds with old spin +1 sit after the three with old spin -1
    localparam logic [THR_IDX_W-1:0] THR_UP_BASE = 3'd3;

    localparam logic [SCNT_W-1:0] SPIN_COUNT_RST = 11'd1024;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UPDATE = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic addr_site; // port A reads the site, else the left neighbor
        logic latch_nbr; // neighbor spins are on the read ports
        logic commit;    // write back, update counters, load results
    } isu_cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    bad;
    } isu_stat_t;

endpackage

`default_nettype wire

@@ hdl/isu_ctrl.sv @@
// Sequencer for the spin update unit: accepts a word, steps the read phases.
// Depends on isu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isu_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire isu_pkg::isu_stat_t stat,
    output isu_pkg::isu_cmd_t      cmd,
    output logic                   busy,
    output logic                   done
);
    import isu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_SITE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start & ~busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                // neighbor reads are in flight here; only updates and reads need the site
                if (!stat.bad && (stat.action == ACT_UPDATE || stat.action == ACT_READ))
                    state_next = S_RD_SITE;
                else
                    state_next = S_EXEC;
            end
            S_RD_SITE:
                state_next = S_EXEC;
            S_EXEC:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (accept)
                busy_reg <= 1'b1;
            else if (state_reg == S_EXEC)
                busy_reg <= 1'b0;
        end
    end

    assign cmd.capture   = accept;
    assign cmd.addr_site = (state_reg == S_RD_SITE);
    assign cmd.latch_nbr = (state_reg == S_RD_SITE);
    assign cmd.commit    = (state_reg == S_EXEC);

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/isu_datapath.sv @@
// Datapath: config registers, spin memory, threshold compare, counters, results.
// Depends on isu_pkg; driven by isu_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module isu_datapath #(
    parameter int MAX_SPINS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire isu_pkg::isu_cmd_t                 cmd,
    output isu_pkg::isu_stat_t                     stat,
    input  wire logic                              cfg_valid,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [isu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [isu_pkg::ACTION_W-1:0]      action,
    input  wire logic [isu_pkg::SITE_W-1:0]        site_index,
    input  wire logic [isu_pkg::RAND_W-1:0]        random_value,
    input  wire logic                              spin_in,
    output logic                                   spin_out,
    output logic                                   spin_changed,
    output logic                                   bad_index,
    output logic [isu_pkg::COUNT_W-1:0]            tried_count,
    output logic [isu_pkg::COUNT_W-1:0]            flip_count
);
    import isu_pkg::*;

    localparam int AW  = $clog2(MAX_SPINS);
    localparam int LW  = $clog2(MAX_SPINS + 1);
    localparam int NW  = (LW > SCNT_W) ? LW : SCNT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SPINS);

    // configuration
    logic [SCNT_W-1:0] spin_count_reg;
    logic [THR_W-1:0]  thr_reg [NUM_THR];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_count_reg <= SPIN_COUNT_RST;
            for (int i = 0; i < NUM_THR; i++)
                thr_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SPIN_COUNT)
                spin_count_reg <= cfg_data[SCNT_W-1:0];
            else if (cfg_index >= CFG_THR_FIRST && cfg_index <= CFG_THR_LAST)
                thr_reg[THR_IDX_W'(cfg_index - CFG_THR_FIRST)] <= cfg_data[THR_W-1:0];
        end
    end

    // ring length in use, clamped to the memory depth
    logic [NW-1:0] ring_len;
    logic [NW-1:0] site_ext;
    assign ring_len = (NW'(spin_count_reg) > MAX_N) ? MAX_N : NW'(spin_count_reg);
    assign site_ext = NW'(site_index);

    // captured word
    action_t           action_reg;
    logic [SITE_W-1:0] site_reg;
    logic [RAND_W-1:0] rand_reg;
    logic              spin_in_reg;
    logic              bad_reg;
    logic [NW-1:0]     ring_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg <= ACT_UPDATE;
            bad_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            action_reg <= action_t'(action);
            bad_reg    <= (action_t'(action) != ACT_CLEAR) && (site_ext >= ring_len);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            site_reg     <= site_index;
            rand_reg     <= random_value;
            spin_in_reg  <= spin_in;
            ring_len_reg <= ring_len;
        end
    end

    assign stat.action = action_reg;
    assign stat.bad    = bad_reg;

    // neighbor addresses with periodic wrap
    logic [NW-1:0] site_w;
    logic [NW-1:0] left_w;
    logic [NW-1:0] right_w;
    logic [NW-1:0] site_inc;
    assign site_w   = NW'(site_reg);
    assign site_inc = site_w + NW'(1);
    assign left_w   = (site_w == '0) ? ring_len_reg - NW'(1) : site_w - NW'(1);
    assign right_w  = (site_inc == ring_len_reg) ? '0 : site_inc;

    // spin memory: one write port, two registered read ports
    logic          spin_mem [MAX_SPINS];
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_w;
    logic          rdata_a;
    logic          rdata_b;
    logic          mem_we;
    logic          mem_wdata;

    assign addr_a = cmd.addr_site ? site_w[AW-1:0] : left_w[AW-1:0];
    assign addr_b = right_w[AW-1:0];
    assign addr_w = site_w[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            spin_mem[addr_w] <= mem_wdata;
        rdata_a <= spin_mem[addr_a];
        rdata_b <= spin_mem[addr_b];
    end

    // neighbor spins held while the site read completes
    logic nbr_l_reg;
    logic nbr_r_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch_nbr)
        begin
            nbr_l_reg <= rdata_a;
            nbr_r_reg <= rdata_b;
        end
    end

    // threshold lookup and compare
    logic [1:0]           ones;
    logic [THR_IDX_W-1:0] thr_idx;
    logic [THR_W-1:0]     thr_sel;
    logic                 new_spin;
    logic                 old_spin;
    assign old_spin = rdata_a;
    assign ones     = {1'b0, nbr_l_reg} + {1'b0, nbr_r_reg};
    assign thr_idx  = old_spin ? THR_UP_BASE + THR_IDX_W'(ones) : THR_IDX_W'(ones);
    assign thr_sel  = thr_reg[thr_idx];
    assign new_spin = ({1'b0, rand_reg} < thr_sel);

    logic is_update;
    logic is_write;
    assign is_update = cmd.commit && !bad_reg && (action_reg == ACT_UPDATE);
    assign is_write  = cmd.commit && !bad_reg && (action_reg == ACT_WRITE);

    assign mem_we    = is_update || is_write;
    assign mem_wdata = is_write ? spin_in_reg : new_spin;

    // counters
    logic [COUNT_W-1:0] tried_reg;
    logic [COUNT_W-1:0] flip_reg;
    logic               flipped;
    assign flipped = (new_spin != old_spin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tried_reg <= '0;
            flip_reg  <= '0;
        end
        else if (cmd.commit && action_reg == ACT_CLEAR)
        begin
            tried_reg <= '0;
            flip_reg  <= '0;
        end
        else if (is_update)
        begin
            if (tried_reg != '1)
                tried_reg <= tried_reg + COUNT_W'(1);
            if (flipped && flip_reg != '1)
                flip_reg <= flip_reg + COUNT_W'(1);
        end
    end

    // result word
    logic spin_out_reg;
    logic changed_reg;
    logic bad_out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            bad_out_reg  <= bad_reg;
            spin_out_reg <= 1'b0;
            changed_reg  <= 1'b0;
            if (!bad_reg)
            begin
                case (action_reg)
                    ACT_UPDATE:
                    begin
                        spin_out_reg <= new_spin;
                        changed_reg  <= flipped;
                    end
                    ACT_WRITE:
                        spin_out_reg <= spin_in_reg;
                    ACT_READ:
                        spin_out_reg <= rdata_a;
                    default:
                        spin_out_reg <= 1'b0;
                endcase
            end
        end
    end

    assign spin_out     = spin_out_reg;
    assign spin_changed = changed_reg;
    assign bad_index    = bad_out_reg;
    assign tried_count  = tried_reg;
    assign flip_count   = flip_reg;

endmodule

`default_nettype wire

@@ hdl/ising_1d_spin_update_unit.sv @@
// Top level of the 1D Ising spin update unit (Metropolis or Gibbs by thresholds).
// Depends on isu_pkg, isu_ctrl and isu_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Command channel: a word is taken at a rising edge with start high and busy
//   low. action selects update, write, read or clear-counters; site_index,
//   random_value and spin_in ride along.
//   Result channel: done pulses for one cycle with spin_out, spin_changed,
//   bad_index, tried_count and flip_count. There is no back-pressure; the
//   receiver must take the word in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0
//   is spin_count, 1..6 are the six thresholds, other indexes are dropped.
//   cfg_ready is always high; write only while the unit is idle.
// Update and read words go through dispatch, site read and execute; write,
// clear and out-of-range words skip the site read. busy drops in the done
// cycle, so a new word can go in then, not before. The order is set by the
// spin memory: both neighbors are read at once on its two read ports, then
// the site, and the write-back happens in the execute cycle.
// Reset: counters clear, spin_count goes to 1024, thresholds to 0. The spin
// memory is not cleared; every site must be written before it is read.

module ising_1d_spin_update_unit #(
    parameter int MAX_SPINS = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [isu_pkg::ACTION_W-1:0]      action,
    input  wire logic [isu_pkg::SITE_W-1:0]        site_index,
    input  wire logic [isu_pkg::RAND_W-1:0]        random_value,
    input  wire logic                              spin_in,
    output logic                                   done,
    output logic                                   spin_out,
    output logic                                   spin_changed,
    output logic                                   bad_index,
    output logic [isu_pkg::COUNT_W-1:0]            tried_count,
    output logic [isu_pkg::COUNT_W-1:0]            flip_count,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [isu_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import isu_pkg::*;

    isu_cmd_t  cmd;
    isu_stat_t stat;

    // config writes are never held off; each is registered on the edge where cfg_valid is high
    assign cfg_ready = 1'b1;

    isu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    isu_datapath #(
        .MAX_SPINS (MAX_SPINS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .site_index   (site_index),
        .random_value (random_value),
        .spin_in      (spin_in),
        .spin_out     (spin_out),
        .spin_changed (spin_changed),
        .bad_index    (bad_index),
        .tried_count  (tried_count),
        .flip_count   (flip_count)
    );

endmodule

`default_nettype wire

@@ hdl/isu_checker.sv @@
// Port-level checks for the spin update unit, bound to the top level.
// Depends on isu_pkg and ising_1d_spin_update_unit.
`timescale 1ns / 1ps
`default_nettype none

module isu_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic                              spin_out,
    input wire logic                              spin_changed,
    input wire logic                              bad_index,
    input wire logic [isu_pkg::COUNT_W-1:0]       flip_count
);

    // an accepted word keeps the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // result shows only once the unit is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // one result per word, never in back-to-back cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // ignored words report no spin
    a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_index) |-> (!spin_out && !spin_changed))
        else $error("bad index with spin data");

    // a flip is always counted
    a_flip_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && spin_changed) |-> (flip_count != '0))
        else $error("flip not counted");

endmodule

bind ising_1d_spin_update_unit isu_checker u_isu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .spin_out     (spin_out),
    .spin_changed (spin_changed),
    .bad_index    (bad_index),
    .flip_count   (flip_count)
);

`default_nettype wire
